FILE: hw/rtl/cnms_pkg.sv
// Package: shared constants and types for the class-aware NMS block.
`default_nettype none
package cnms_pkg;
    localparam int MaxDetectionsDefault = 64;
    localparam logic [15:0] IouThresholdReset = 16'd29491;
    localparam int BoxW = 64;
    localparam int ScW = 23;
    localparam logic [0:0] RegIouThreshold = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SUP_I,
        ST_SUP_IW,
        ST_SUP_J,
        ST_SUP_JW,
        ST_SUP_M1,
        ST_SUP_M2,
        ST_SUP_M3,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] thr;
    } iou_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/cnms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cnms_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(Depth)-1:0] waddr,
    input  wire  [Width-1:0]         wdata,
    input  wire  [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/cnms_iou.sv
// Multi-cycle IoU test unit: one shared 37x37 signed multiplier, one product per cycle.
`default_nettype none
module cnms_iou
    import cnms_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  iou_ctl_t       ctl,
    input  wire  [BoxW-1:0] box_a,
    input  wire  [BoxW-1:0] box_b,
    output logic           done,
    output logic           over
);
    logic [2:0] step_reg, step_next;
    logic signed [17:0] wa_reg, ha_reg, wb_reg, hb_reg, iw_reg, ih_reg;
    logic signed [35:0] inter_reg, aa_reg, ab_reg;
    logic signed [37:0] uni_reg;
    logic signed [36:0] ma, mb;
    logic signed [73:0] prod;
    logic signed [17:0] al, at, ar, ab2, bl, bt, br, bb, iwc, ihc;

    always_comb begin
        al = 18'(signed'(box_a[15:0]));  at = 18'(signed'(box_a[31:16]));
        ar = 18'(signed'(box_a[47:32])); ab2 = 18'(signed'(box_a[63:48]));
        bl = 18'(signed'(box_b[15:0]));  bt = 18'(signed'(box_b[31:16]));
        br = 18'(signed'(box_b[47:32])); bb = 18'(signed'(box_b[63:48]));
        iwc = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        ihc = ((ab2 < bb) ? ab2 : bb) - ((at > bt) ? at : bt);
        ma = '0; mb = '0;
        case (step_reg)
            3'd1: begin ma = 37'(iw_reg); mb = 37'(ih_reg); end
            3'd2: begin ma = 37'(wa_reg); mb = 37'(ha_reg); end
            3'd3: begin ma = 37'(wb_reg); mb = 37'(hb_reg); end
            default: begin ma = 37'(uni_reg); mb = 37'(signed'({1'b0, ctl.thr})); end
        endcase
        prod = 74'(ma) * 74'(mb);
        step_next = step_reg;
        if (ctl.start) begin
            step_next = 3'd1;
        end else if (step_reg != 3'd0 && step_reg != 3'd6) begin
            step_next = step_reg + 3'd1;
        end else if (step_reg == 3'd6) begin
            step_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
        end else begin
            step_reg <= step_next;
        end
        if (ctl.start) begin
            iw_reg <= (iwc < 0) ? 18'sd0 : iwc;
            ih_reg <= (ihc < 0) ? 18'sd0 : ihc;
            wa_reg <= ar - al; ha_reg <= ab2 - at;
            wb_reg <= br - bl; hb_reg <= bb - bt;
        end
        case (step_reg)
            3'd1: inter_reg <= prod[35:0];
            3'd2: aa_reg <= prod[35:0];
            3'd3: ab_reg <= prod[35:0];
            3'd4: uni_reg <= 38'(aa_reg) + 38'(ab_reg) - 38'(inter_reg);
            3'd5: begin
                over <= (56'(signed'({inter_reg, 16'd0})) > signed'(prod[55:0]));
            end
            default: ;
        endcase
    end
    assign done = (step_reg == 3'd6);
endmodule
`default_nettype wire

FILE: hw/rtl/class_aware_nms_unit.sv
// Top level: class-aware greedy NMS with load, sort, suppress and emit sequencer.
//
// Boxes load one per beat. The beat flagged final starts an insertion sort
// (quadratic in the set size) and then a greedy pass: a pair of the same
// class goes through the shared multiplier unit, a pair of different classes
// skips it; kept boxes then stream out one at a time, subject to output stalls.
// s_tready is low from the final beat until the last result is loaded into
// the output register.
`default_nettype none
module class_aware_nms_unit
    import cnms_pkg::*;
#(
    parameter int MAX_DETECTIONS = MaxDetectionsDefault
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,  // left, top, right, bottom, score, class_index
    input  wire         s_tlast,  // final_box
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,  // kept_left/top/right/bottom, kept_score, kept_class
    output logic        m_tlast,  // last_kept
    output logic        m_tuser,  // overflowed
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(MAX_DETECTIONS);
    localparam int CW = $clog2(MAX_DETECTIONS + 1);

    state_t state_reg, state_next;
    logic [15:0] thr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [MAX_DETECTIONS-1:0] sup_reg, sup_next;
    logic [6:0] ci_reg;
    logic [BoxW-1:0] bi_reg;
    logic [87:0] out_reg;
    logic out_v_reg, out_last_reg, out_ovf_reg;

    // memories
    logic box_we, sc_we, ord_we, kl_we;
    logic [AW-1:0] box_wa, box_ra, sc_wa, sc_ra, ord_wa, ord_ra, kl_wa, kl_ra;
    logic [BoxW-1:0] box_wd, box_rd;
    logic [ScW-1:0] sc_wd, sc_rd, cs_rd;
    logic [AW-1:0] ord_wd, ord_rd, kl_wd, kl_rd;

    cnms_ram #(.Width(BoxW), .Depth(MAX_DETECTIONS)) u_box (.aclk, .we(box_we),
        .waddr(box_wa), .wdata(box_wd), .raddr(box_ra), .rdata(box_rd));
    cnms_ram #(.Width(ScW), .Depth(MAX_DETECTIONS)) u_sc (.aclk, .we(sc_we),
        .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));
    cnms_ram #(.Width(AW), .Depth(MAX_DETECTIONS)) u_ord (.aclk, .we(ord_we),
        .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
    cnms_ram #(.Width(AW), .Depth(MAX_DETECTIONS)) u_kept (.aclk, .we(kl_we),
        .waddr(kl_wa), .wdata(kl_wd), .raddr(kl_ra), .rdata(kl_rd));
    // score of the slot being inserted, read through a second port copy
    cnms_ram #(.Width(ScW), .Depth(MAX_DETECTIONS)) u_sc2 (.aclk, .we(sc_we),
        .waddr(sc_wa), .wdata(sc_wd), .raddr(i_reg[AW-1:0]), .rdata(cs_rd));

    iou_ctl_t iou_ctl;
    logic iou_done, iou_over;
    cnms_iou u_iou (.aclk, .aresetn, .ctl(iou_ctl), .box_a(bi_reg), .box_b(box_rd),
        .done(iou_done), .over(iou_over));

    logic [CW-1:0] nk_reg, nk_next;
    logic in_acc;
    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign pready = 1'b1;
    assign prdata = {16'd0, thr_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; ovf_next = ovf_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; nk_next = nk_reg;
        sup_next = sup_reg;
        box_we = 1'b0; sc_we = 1'b0; ord_we = 1'b0; kl_we = 1'b0;
        box_wa = cnt_reg[AW-1:0]; sc_wa = cnt_reg[AW-1:0];
        box_wd = s_tdata[63:0]; sc_wd = {s_tdata[79:64], s_tdata[86:80]};
        box_ra = '0; sc_ra = '0; ord_ra = '0; kl_ra = '0;
        ord_wa = j_reg[AW-1:0]; ord_wd = i_reg[AW-1:0];
        kl_wa = nk_reg[AW-1:0]; kl_wd = ord_rd;
        iou_ctl.start = 1'b0; iou_ctl.thr = thr_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (cnt_reg < CW'(MAX_DETECTIONS)) begin
                        box_we = 1'b1; sc_we = 1'b1; cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = '0; j_next = '0; k_next = '0; state_next = ST_SORT_RD;
                        sc_ra = '0;
                    end
                end
            end
            ST_SORT_RD: begin
                // j: insertion position; read order[j-1] then its score
                if (i_reg == cnt_reg) begin
                    i_next = '0; nk_next = '0; sup_next = '0; state_next = ST_SUP_I;
                end else if (j_reg == '0) begin
                    ord_we = 1'b1;
                    i_next = i_reg + 1'b1; j_next = i_reg + 1'b1;
                end else begin
                    ord_ra = AW'(j_reg - 1'b1);
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                ord_ra = AW'(j_reg - 1'b1);
                sc_ra = ord_rd;
                if (k_reg == '0) begin
                    k_next = CW'(1);
                end else begin
                    k_next = '0;
                    if (sc_rd[22:7] < cs_rd[22:7]) begin
                        ord_we = 1'b1; ord_wd = ord_rd; j_next = j_reg - 1'b1;
                    end else begin
                        ord_we = 1'b1;
                        i_next = i_reg + 1'b1; j_next = i_reg + 1'b1;
                    end
                    state_next = ST_SORT_RD;
                end
            end
            ST_SUP_I: begin
                if (i_reg == cnt_reg) begin
                    k_next = '0; state_next = ST_EMIT_RD;
                end else if (sup_reg[i_reg[AW-1:0]]) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    ord_ra = i_reg[AW-1:0]; k_next = '0; state_next = ST_SUP_IW;
                end
            end
            ST_SUP_IW: begin
                ord_ra = i_reg[AW-1:0];
                box_ra = ord_rd; sc_ra = ord_rd;
                if (k_reg == '0) begin
                    k_next = CW'(1);
                end else begin
                    kl_we = 1'b1; nk_next = nk_reg + 1'b1;
                    j_next = i_reg + 1'b1; state_next = ST_SUP_J;
                end
            end
            ST_SUP_J: begin
                if (j_reg == cnt_reg) begin
                    i_next = i_reg + 1'b1; state_next = ST_SUP_I;
                end else if (sup_reg[j_reg[AW-1:0]]) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    ord_ra = j_reg[AW-1:0]; k_next = '0; state_next = ST_SUP_JW;
                end
            end
            ST_SUP_JW: begin
                ord_ra = j_reg[AW-1:0];
                box_ra = ord_rd; sc_ra = ord_rd;
                if (k_reg == '0) begin
                    k_next = CW'(1);
                end else if (sc_rd[6:0] != ci_reg) begin
                    j_next = j_reg + 1'b1; state_next = ST_SUP_J;
                end else begin
                    iou_ctl.start = 1'b1; state_next = ST_SUP_M1;
                end
            end
            ST_SUP_M1: begin
                box_ra = ord_rd;
                if (iou_done) begin
                    if (iou_over) sup_next[j_reg[AW-1:0]] = 1'b1;
                    j_next = j_reg + 1'b1; state_next = ST_SUP_J;
                end
            end
            ST_EMIT_RD: begin
                kl_ra = k_reg[AW-1:0]; state_next = ST_EMIT_WAIT; j_next = '0;
            end
            ST_EMIT_WAIT: begin
                kl_ra = k_reg[AW-1:0]; box_ra = kl_rd; sc_ra = kl_rd;
                if (j_reg == '0) begin
                    j_next = CW'(1);
                end else if (!out_v_reg || m_tready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == nk_reg) begin
                    cnt_next = '0; ovf_next = 1'b0; state_next = ST_LOAD;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            thr_reg <= IouThresholdReset;
            cnt_reg <= '0; ovf_reg <= 1'b0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0; nk_reg <= '0;
            sup_reg <= '0; out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next; ovf_reg <= ovf_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; nk_reg <= nk_next;
            sup_reg <= sup_next;
            if (psel && penable && pwrite && paddr[2] == RegIouThreshold) begin
                thr_reg <= pwdata[15:0];
            end
            if (state_reg == ST_EMIT) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
        if (state_reg == ST_SUP_IW && k_reg != '0) begin
            ci_reg <= sc_rd[6:0]; bi_reg <= box_rd;
        end
        if (state_reg == ST_EMIT) begin
            out_reg <= {1'b0, sc_rd[6:0], sc_rd[22:7], box_rd};
            out_last_reg <= (k_reg + 1'b1 == nk_reg);
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;
    assign m_tlast = out_last_reg;
    assign m_tuser = out_ovf_reg;

    a_ready_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_LOAD) else $error("ready outside load");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_DETECTIONS)) else $error("count overflow");
    a_emit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && state_next == ST_LOAD) |=> cnt_reg == '0)
        else $error("count not cleared");
endmodule
`default_nettype wire

FILE: sim/class_aware_nms_unit_tb.sv
// Testbench for class_aware_nms_unit: directed and random detection sets scored against a built-in NMS predictor.
`timescale 1ns / 100ps
module class_aware_nms_unit_tb;
    import cnms_pkg::*;

    localparam int  Depth = 64;
    localparam longint CycleLimit = 2_000_000;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic        [15:0] score;
        logic        [6:0]  cls;
        logic               flag;   // final_box on input, last_kept on output
    } det_t;

    typedef struct packed {
        det_t d;
        logic ovf;
    } kept_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    class_aware_nms_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    det_t   pending_boxes[$];
    kept_t  kept_q[$];
    det_t   cur_box;
    det_t   box_set[Depth];
    int     set_count = 0;
    logic   set_overflow = 1'b0;
    logic [15:0] iou_thr = IouThresholdReset;
    logic   s_fire = 1'b0;
    logic   quiet = 1'b0;
    int     send_gap = 0;
    int     recv_stall = 0;
    int     errors = 0;
    longint cycles = 0;

    task automatic queue_box(det_t d);
        pending_boxes = {pending_boxes, d};
    endtask

    function automatic logic too_close(det_t a, det_t b, logic [15:0] thr);
        longint iw, ih, inter, area_a, area_b, uni;
        iw = ((a.right < b.right) ? longint'(a.right) : longint'(b.right))
           - ((a.left > b.left) ? longint'(a.left) : longint'(b.left));
        ih = ((a.bottom < b.bottom) ? longint'(a.bottom) : longint'(b.bottom))
           - ((a.top > b.top) ? longint'(a.top) : longint'(b.top));
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        area_a = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top));
        area_b = (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top));
        uni = area_a + area_b - inter;
        return inter * 65536 > longint'(thr) * uni;
    endfunction

    task automatic take_box(det_t b);
        int ord[Depth];
        logic gone[Depth];
        int j, cur, nk;
        kept_t k;
        int kept_idx[Depth];
        if (set_count < Depth) begin
            box_set[set_count] = b;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!b.flag) return;
        for (int i = 0; i < set_count; i++) begin
            cur = i;
            j = i;
            while (j > 0 && box_set[ord[j-1]].score < box_set[cur].score) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = cur;
            gone[i] = 1'b0;
        end
        nk = 0;
        for (int i = 0; i < set_count; i++) begin
            if (gone[i]) continue;
            kept_idx[nk++] = ord[i];
            for (int m = i + 1; m < set_count; m++) begin
                if (gone[m]) continue;
                if (box_set[ord[i]].cls == box_set[ord[m]].cls &&
                    too_close(box_set[ord[i]], box_set[ord[m]], iou_thr))
                    gone[m] = 1'b1;
            end
        end
        for (int i = 0; i < nk; i++) begin
            k.d = box_set[kept_idx[i]];
            k.d.flag = (i == nk - 1);
            k.ovf = set_overflow;
            kept_q = {kept_q, k};
        end
        set_count = 0;
        set_overflow = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) take_box(cur_box);
            if (m_tvalid && m_tready) begin
                kept_t got, want;
                got.d = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                         m_tdata[79:64], m_tdata[86:80], m_tlast};
                got.ovf = m_tuser;
                if (kept_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = kept_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: kept box mismatch, expected %h, actual %h",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_boxes.size() > 0) begin
                cur_box = pending_boxes.pop_front();
                s_tdata <= {1'b0, cur_box.cls, cur_box.score, cur_box.bottom, cur_box.right,
                            cur_box.top, cur_box.left};
                s_tlast <= cur_box.flag;
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (recv_stall > 0) begin
            m_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) recv_stall <= $urandom_range(1, 12);
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == {RegIouThreshold, 2'b00}) iou_thr = value[15:0];
    endtask

    task automatic drain();
        while (pending_boxes.size() > 0 || s_tvalid || kept_q.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic det_t mk(int l, int t, int r, int b, int sc, int c, int fin);
        det_t d;
        d.left = 16'(l); d.top = 16'(t); d.right = 16'(r); d.bottom = 16'(b);
        d.score = 16'(sc); d.cls = 7'(c); d.flag = (fin != 0);
        return d;
    endfunction

    // mostly clustered, well-formed boxes; some wild ones and near copies
    task automatic add_set(int n);
        det_t d, prev;
        int bx, by, w, h, pick;
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
        for (int i = 0; i < n; i++) begin
            pick = int'($urandom_range(0, 19));
            w = int'($urandom_range(0, 400));
            h = int'($urandom_range(0, 400));
            if (pick == 0) begin
                d = mk($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 127), 0);
            end else begin
                d.left = 16'(bx + int'($urandom_range(0, 300)));
                d.top = 16'(by + int'($urandom_range(0, 300)));
                d.right = (pick == 1) ? 16'(int'(d.left) - w) : 16'(int'(d.left) + w);
                d.bottom = (pick == 2) ? 16'(int'(d.top) - h) : 16'(int'(d.top) + h);
                d.score = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'(1000 * $urandom_range(0, 8));
                d.cls = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 2));
                if (i > 0 && pick < 7) begin
                    d = prev;
                    d.left += 16'($urandom_range(0, 20));
                    d.bottom -= 16'($urandom_range(0, 20));
                    d.score = 16'($urandom_range(0, 65535));
                end
            end
            d.flag = (i == n - 1);
            prev = d;
            queue_box(d);
        end
    endtask

    task automatic random_phase(int items, bit with_overflow);
        int sent, n;
        sent = 0;
        if (with_overflow) begin
            n = int'($urandom_range(65, 68));
            add_set(n);
            sent += n;
        end
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                            : int'($urandom_range(1, 12));
            add_set(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes, identical boxes per class, ties, inverted and zero-area boxes
        queue_box(mk(-32768, -32768, 32767, 32767, 65535, 127, 0));
        queue_box(mk(-32768, -32768, 32767, 32767, 0, 127, 0));
        queue_box(mk(100, 100, 200, 200, 500, 0, 0));
        queue_box(mk(100, 100, 200, 200, 500, 0, 0));
        queue_box(mk(100, 100, 200, 200, 500, 1, 0));
        queue_box(mk(110, 105, 205, 190, 700, 0, 0));
        queue_box(mk(300, 300, 250, 250, 900, 2, 0));
        queue_box(mk(240, 240, 310, 310, 800, 2, 0));
        queue_box(mk(50, 50, 50, 50, 400, 3, 0));
        queue_box(mk(50, 50, 50, 50, 300, 3, 0));
        queue_box(mk(32767, 32767, -32768, -32768, 200, 4, 0));
        queue_box(mk(0, 0, 1000, 10, 65535, 5, 1));
        queue_box(mk(7, 7, 9, 9, 1234, 9, 1));
        queue_box(mk(0, 0, 16, 16, 100, 6, 0));
        queue_box(mk(0, 0, 16, 16, 100, 6, 1));
        drain();

        write_reg(3'd4, 32'h0000_0000);
        random_phase(50, 0);
        write_reg({RegIouThreshold, 2'b00}, 32'd0);
        random_phase(50, 1);
        write_reg({RegIouThreshold, 2'b00}, 32'hFFFF_FFFF);
        random_phase(45, 0);
        write_reg({RegIouThreshold, 2'b00}, 32'd1);
        random_phase(45, 0);
        write_reg({RegIouThreshold, 2'b00}, 32'd32768);
        random_phase(50, 1);
        write_reg({RegIouThreshold, 2'b00}, $urandom_range(0, 65535));
        random_phase(45, 0);
        write_reg({RegIouThreshold, 2'b00}, 32'd29491);
        quiet = 1'b1;
        random_phase(45, 0);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/cnms_pkg.sv
hw/rtl/cnms_ram.sv
hw/rtl/cnms_iou.sv
hw/rtl/class_aware_nms_unit.sv
sim/class_aware_nms_unit_tb.sv
